// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

    // Field widths of the request and result items
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Default number of cells in the chain
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ_IDX   = 3'd4,
        MODE_WRITE_IDX  = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Broadcast controls shared by every cell of the chain
    typedef struct packed {
        logic shift_up;    // each cell takes its lower neighbor (push front)
        logic shift_down;  // each cell takes its upper neighbor (pop front)
        logic wr_en;       // the selected cell takes the request word
    } t_cell_ctrl;

endpackage

// ===== sv/circular_deque.sv =====
// Channel   Dir  Bits  Contents
// s_axis    in   48    request: mode, index, value
// m_axis    out  48    result: data, status, count, empty flag
//
// Each request is decoded against the fill count and acts on the chain of
// word cells in the cycle it transfers; the result is registered and a new
// request is taken in the same cycle the result leaves.
// The chain keeps the front element in cell zero; a push or pop at the front
// moves every cell one place, a push or pop at the back touches one cell.
// Reset (synchronous, active low) clears the fill count and the result
// valid; cell words are not cleared. A stalled result holds s_axis_tready low.
module circular_deque #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] mode, [8:3] index, [40:9] value, [47:41] zero
    input  logic [cdq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] data, [33:32] status, [40:34] count, [41] empty_res, [47:42] zero
    output logic [cdq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CXW = (CW > cdq_pkg::COUNT_W) ? CW : cdq_pkg::COUNT_W;
    localparam int PAD_W = cdq_pkg::OUT_TDATA_W - cdq_pkg::DATA_W
                         - cdq_pkg::STATUS_W - cdq_pkg::COUNT_W - 1;

    logic                             w_accept;
    logic [cdq_pkg::MODE_W-1:0]       w_mode;
    logic [cdq_pkg::INDEX_W-1:0]      w_index;
    logic [cdq_pkg::DATA_W-1:0]       w_value;
    cdq_pkg::t_cell_ctrl              w_ctrl;
    logic [AW-1:0]                    w_wr_addr;
    logic [AW-1:0]                    w_rd_addr;
    logic                             w_rd_en;
    cdq_pkg::t_status                 w_status;
    logic [CW-1:0]                    w_fill_next;
    logic [CXW-1:0]                   w_count_ext;
    logic [cdq_pkg::DATA_W-1:0]       w_word [CAPACITY];
    logic [cdq_pkg::DATA_W-1:0]       w_rd_data;

    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [cdq_pkg::DATA_W-1:0]       r_data;
    logic [cdq_pkg::STATUS_W-1:0]     r_status;
    logic [cdq_pkg::COUNT_W-1:0]      r_count;
    logic                             r_empty;

    // Unpack the request
    assign w_mode  = s_axis_tdata[2:0];
    assign w_index = s_axis_tdata[8:3];
    assign w_value = s_axis_tdata[40:9];

    // Take a request whenever the result register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    cdq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_mode      (w_mode),
        .i_index     (w_index),
        .o_ctrl      (w_ctrl),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .o_rd_en     (w_rd_en),
        .o_status    (w_status),
        .o_fill_next (w_fill_next)
    );

    // Chain of word cells, cell zero holds the front element
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [cdq_pkg::DATA_W-1:0] w_prev;
        logic [cdq_pkg::DATA_W-1:0] w_next;

        if (k == 0) begin : g_first
            assign w_prev = w_value;
        end else begin : g_inner_prev
            assign w_prev = w_word[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner_next
            assign w_next = w_word[k+1];
        end

        cdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_sel   (w_wr_addr == AW'(k)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_value (w_value),
            .o_word  (w_word[k])
        );
    end

    // Select the word being popped or read
    assign w_rd_data   = w_rd_en ? w_word[w_rd_addr] : '0;
    assign w_count_ext = CXW'(w_fill_next);

    // Hold the result until the downstream side takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= w_rd_data;
            r_status <= w_status;
            r_count  <= w_count_ext[cdq_pkg::COUNT_W-1:0];
            r_empty  <= (w_fill_next == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {PAD_W'(0), r_empty, r_count, r_status, r_data};

endmodule

// ===== sv/cdq_cell.sv =====
module cdq_cell (
    input  logic                       i_clk,
    input  cdq_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_sel,
    input  logic [cdq_pkg::DATA_W-1:0] i_prev,
    input  logic [cdq_pkg::DATA_W-1:0] i_next,
    input  logic [cdq_pkg::DATA_W-1:0] i_value,
    output logic [cdq_pkg::DATA_W-1:0] o_word
);

    logic [cdq_pkg::DATA_W-1:0] r_word;
    logic [cdq_pkg::DATA_W-1:0] n_word;

    // Pick the word this cell holds next: direct write, neighbor, or hold
    always_comb begin
        n_word = r_word;
        if (i_ctrl.wr_en && i_sel) begin
            n_word = i_value;
        end else if (i_ctrl.shift_up) begin
            n_word = i_prev;
        end else if (i_ctrl.shift_down) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== sv/cdq_ctrl.sv =====
module cdq_ctrl #(
    parameter int CAPACITY = cdq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [cdq_pkg::MODE_W-1:0]    i_mode,
    input  logic [cdq_pkg::INDEX_W-1:0]   i_index,
    output cdq_pkg::t_cell_ctrl           o_ctrl,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [AW-1:0]                 o_rd_addr,
    output logic                          o_rd_en,
    output cdq_pkg::t_status              o_status,
    output logic [CW-1:0]                 o_fill_next
);

    // Common width for comparing the request index with the fill count
    localparam int IW = (CW > cdq_pkg::INDEX_W) ? CW : cdq_pkg::INDEX_W;

    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        n_fill;
    cdq_pkg::t_cell_ctrl  w_ctrl;
    logic [IW-1:0]        w_index;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_in_range;

    assign w_index    = IW'(i_index);
    assign w_full     = (r_fill == CW'(CAPACITY));
    assign w_empty    = (r_fill == '0);
    assign w_in_range = (w_index < IW'(r_fill));

    // Decode the request against the current fill
    always_comb begin
        n_fill    = r_fill;
        o_status  = cdq_pkg::ST_OK;
        w_ctrl    = '0;
        o_wr_addr = '0;
        o_rd_addr = '0;
        o_rd_en   = 1'b0;
        case (cdq_pkg::t_mode'(i_mode))
            cdq_pkg::MODE_PUSH_BACK: begin
                if (w_full) begin
                    o_status = cdq_pkg::ST_FULL;
                end else begin
                    w_ctrl.wr_en = 1'b1;
                    o_wr_addr    = r_fill[AW-1:0];
                    n_fill       = r_fill + CW'(1);
                end
            end
            cdq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    o_status = cdq_pkg::ST_FULL;
                end else begin
                    w_ctrl.shift_up = 1'b1;
                    n_fill          = r_fill + CW'(1);
                end
            end
            cdq_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    o_status = cdq_pkg::ST_EMPTY;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_fill - CW'(1));
                    n_fill    = r_fill - CW'(1);
                end
            end
            cdq_pkg::MODE_POP_FRONT: begin
                if (w_empty) begin
                    o_status = cdq_pkg::ST_EMPTY;
                end else begin
                    o_rd_en           = 1'b1;
                    w_ctrl.shift_down = 1'b1;
                    n_fill            = r_fill - CW'(1);
                end
            end
            cdq_pkg::MODE_READ_IDX: begin
                if (!w_in_range) begin
                    o_status = cdq_pkg::ST_RANGE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_index[AW-1:0];
                end
            end
            cdq_pkg::MODE_WRITE_IDX: begin
                if (!w_in_range) begin
                    o_status = cdq_pkg::ST_RANGE;
                end else begin
                    w_ctrl.wr_en = 1'b1;
                    o_wr_addr    = w_index[AW-1:0];
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // Drive the chain only on a transfer
    assign o_ctrl      = i_accept ? w_ctrl : '0;
    assign o_fill_next = n_fill;

    // Advance the fill count on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_status != cdq_pkg::ST_OK) |=> (r_fill == $past(r_fill)))
        else $error("rejected request changed the fill count");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.shift_up, o_ctrl.shift_down, o_ctrl.wr_en}))
        else $error("more than one chain action at once");

    a_idle_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |-> (o_ctrl == '0))
        else $error("chain driven without a transfer");

endmodule
